>>> hdl/lgrm_pkg.sv
// shared types, codes and constants of the local grid rotate max merge block
package lgrm_pkg;

	localparam int MAP_SIZE  = 512;
	localparam int MAP_W     = $clog2(MAP_SIZE);
	localparam int ADDR_W    = 2 * MAP_W;
	localparam int LOCAL_DIM = 256;
	localparam int CELL_W    = 9;

	// shared multiplier and accumulator widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 49;
	localparam int SUM_W   = PROD_W + 17;
	localparam int COORD_W = SUM_W - 32;

	localparam logic FUNC_MERGE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	typedef enum logic [2:0] {
		ST_RAISED    = 3'd0,
		ST_UNCHANGED = 3'd1,
		ST_UNKNOWN   = 3'd2,
		ST_OUTSIDE   = 3'd3,
		ST_READ      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_POSE_X     = 3'd0,
		REG_POSE_Y     = 3'd1,
		REG_COS_YAW    = 3'd2,
		REG_SIN_YAW    = 3'd3,
		REG_LOCAL_RES  = 3'd4,
		REG_LOCAL_COLS = 3'd5,
		REG_LOCAL_ROWS = 3'd6,
		REG_CELLS_PM   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic              func;
		logic [8:0]        cell_col;
		logic [8:0]        cell_row;
		logic signed [7:0] occupancy;
	} in_item_t;

	typedef struct packed {
		status_t    status;
		logic [8:0] target_col;
		logic [8:0] target_row;
		logic [6:0] stored_value;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [15:0] cos_yaw;
		logic signed [15:0] sin_yaw;
		logic [20:0]        local_resolution;
		logic [8:0]         local_cols;
		logic [8:0]         local_rows;
		logic [26:0]        global_cells_per_meter;
	} cfg_t;

	typedef struct packed {
		logic       go;
		logic [8:0] col;
		logic [8:0] row;
	} xf_req_t;

	typedef struct packed {
		logic             done;
		logic             on_map;
		logic [MAP_W-1:0] col;
		logic [MAP_W-1:0] row;
	} xf_rsp_t;

	typedef enum logic [2:0] {
		T_CLEAR,
		T_IDLE,
		T_XFORM,
		T_READ,
		T_WRITE
	} top_state_t;

	typedef enum logic [3:0] {
		X_IDLE,
		X_LX,
		X_LY,
		X_WX0,
		X_WX1,
		X_WY0,
		X_WY1,
		X_GX0,
		X_GX1,
		X_GY0,
		X_GY1,
		X_DONE
	} xf_state_t;

endpackage

>>> hdl/local_grid_rotate_max_merge_core.sv
// top level: register port, global map memory and item sequencer
// A merge item runs in order: ten products go through one shared 33x18 multiplier, then the
// global map cell is read and, if the new value is greater, written back; its result appears
// on result with done high for one cycle at the end. A merge whose target lies outside the map
// skips the map read and write, a read item skips the multiplier and an unknown cell skips
// both. Results are never held off: done is a single-cycle strobe and must be taken as it
// comes. After reset the global map is cleared one cell a cycle with busy high;
// configuration writes are taken during that time, items are not.
module local_grid_rotate_max_merge_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                start,
	input  lgrm_pkg::in_item_t  cmd,
	output logic                busy,
	output logic                done,
	output lgrm_pkg::out_item_t result
);

	lgrm_pkg::cfg_t cfg_q;
	lgrm_pkg::reg_idx_t widx, ridx;
	logic cfg_wr;
	logic [8:0] cnt_wr;

	lgrm_pkg::top_state_t state_q, state_d;
	lgrm_pkg::xf_req_t xreq;
	lgrm_pkg::xf_rsp_t xrsp;

	logic [6:0] mem [lgrm_pkg::MAP_SIZE * lgrm_pkg::MAP_SIZE];
	logic [lgrm_pkg::ADDR_W-1:0] clr_q, waddr;
	logic [lgrm_pkg::MAP_W-1:0] acol_q, arow_q, acol_d, arow_d;
	logic [6:0] rdata_q, val_q, wdata;
	logic func_q, mem_we, load_addr, emit, done_q;
	lgrm_pkg::out_item_t emit_item, result_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign widx   = lgrm_pkg::reg_idx_t'(paddr[4:2]);
	assign ridx   = lgrm_pkg::reg_idx_t'(paddr[4:2]);
	assign cnt_wr = (pwdata[8:0] > 9'(lgrm_pkg::LOCAL_DIM)) ? 9'(lgrm_pkg::LOCAL_DIM)
		: pwdata[8:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pose_x                 <= '0;
			cfg_q.pose_y                 <= '0;
			cfg_q.cos_yaw                <= 16'sd16384;
			cfg_q.sin_yaw                <= '0;
			cfg_q.local_resolution       <= 21'd6554;
			cfg_q.local_cols             <= 9'(lgrm_pkg::LOCAL_DIM);
			cfg_q.local_rows             <= 9'(lgrm_pkg::LOCAL_DIM);
			cfg_q.global_cells_per_meter <= 27'd655360;
		end else if (cfg_wr) begin
			unique case (widx)
				lgrm_pkg::REG_POSE_X:     cfg_q.pose_x <= pwdata;
				lgrm_pkg::REG_POSE_Y:     cfg_q.pose_y <= pwdata;
				lgrm_pkg::REG_COS_YAW:    cfg_q.cos_yaw <= pwdata[15:0];
				lgrm_pkg::REG_SIN_YAW:    cfg_q.sin_yaw <= pwdata[15:0];
				lgrm_pkg::REG_LOCAL_RES:  cfg_q.local_resolution <= pwdata[20:0];
				lgrm_pkg::REG_LOCAL_COLS: cfg_q.local_cols <= cnt_wr;
				lgrm_pkg::REG_LOCAL_ROWS: cfg_q.local_rows <= cnt_wr;
				lgrm_pkg::REG_CELLS_PM:   cfg_q.global_cells_per_meter <= pwdata[26:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			lgrm_pkg::REG_POSE_X:     prdata = cfg_q.pose_x;
			lgrm_pkg::REG_POSE_Y:     prdata = cfg_q.pose_y;
			lgrm_pkg::REG_COS_YAW:    prdata = {16'b0, cfg_q.cos_yaw};
			lgrm_pkg::REG_SIN_YAW:    prdata = {16'b0, cfg_q.sin_yaw};
			lgrm_pkg::REG_LOCAL_RES:  prdata = {11'b0, cfg_q.local_resolution};
			lgrm_pkg::REG_LOCAL_COLS: prdata = {23'b0, cfg_q.local_cols};
			lgrm_pkg::REG_LOCAL_ROWS: prdata = {23'b0, cfg_q.local_rows};
			lgrm_pkg::REG_CELLS_PM:   prdata = {5'b0, cfg_q.global_cells_per_meter};
			default:                  prdata = '0;
		endcase
	end

	lgrm_xform u_xform (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (xreq),
		.rsp    (xrsp)
	);

	// item sequencer
	always_comb begin
		state_d   = state_q;
		xreq.go   = 1'b0;
		xreq.col  = cmd.cell_col;
		xreq.row  = cmd.cell_row;
		load_addr = 1'b0;
		acol_d    = xrsp.col;
		arow_d    = xrsp.row;
		mem_we    = 1'b0;
		waddr     = {arow_q, acol_q};
		wdata     = val_q;
		emit      = 1'b0;
		emit_item = '{status: lgrm_pkg::ST_UNKNOWN, target_col: '0, target_row: '0,
			stored_value: '0};
		unique case (state_q)
			lgrm_pkg::T_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
				wdata  = '0;
				if (clr_q == '1) state_d = lgrm_pkg::T_IDLE;
			end
			lgrm_pkg::T_IDLE: begin
				if (start) begin
					if (cmd.func == lgrm_pkg::FUNC_READ) begin
						if ({23'b0, cmd.cell_col} < 32'(lgrm_pkg::MAP_SIZE) &&
							{23'b0, cmd.cell_row} < 32'(lgrm_pkg::MAP_SIZE)) begin
							load_addr = 1'b1;
							acol_d    = cmd.cell_col[lgrm_pkg::MAP_W-1:0];
							arow_d    = cmd.cell_row[lgrm_pkg::MAP_W-1:0];
							state_d   = lgrm_pkg::T_READ;
						end else begin
							emit             = 1'b1;
							emit_item.status = lgrm_pkg::ST_OUTSIDE;
						end
					end else if (cmd.occupancy[7]) begin
						emit = 1'b1;
					end else begin
						xreq.go = 1'b1;
						state_d = lgrm_pkg::T_XFORM;
					end
				end
			end
			lgrm_pkg::T_XFORM: begin
				if (xrsp.done) begin
					if (xrsp.on_map) begin
						load_addr = 1'b1;
						state_d   = lgrm_pkg::T_READ;
					end else begin
						emit             = 1'b1;
						emit_item.status = lgrm_pkg::ST_OUTSIDE;
						state_d          = lgrm_pkg::T_IDLE;
					end
				end
			end
			lgrm_pkg::T_READ: begin
				state_d = lgrm_pkg::T_WRITE;
			end
			lgrm_pkg::T_WRITE: begin
				emit                 = 1'b1;
				emit_item.target_col = 9'(acol_q);
				emit_item.target_row = 9'(arow_q);
				if (func_q == lgrm_pkg::FUNC_MERGE && val_q > rdata_q) begin
					mem_we                 = 1'b1;
					emit_item.status       = lgrm_pkg::ST_RAISED;
					emit_item.stored_value = val_q;
				end else begin
					emit_item.status = (func_q == lgrm_pkg::FUNC_READ) ? lgrm_pkg::ST_READ
						: lgrm_pkg::ST_UNCHANGED;
					emit_item.stored_value = rdata_q;
				end
				state_d = lgrm_pkg::T_IDLE;
			end
			default: state_d = lgrm_pkg::T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgrm_pkg::T_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (state_q == lgrm_pkg::T_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) result_q <= emit_item;
		if (state_q == lgrm_pkg::T_IDLE && start) begin
			func_q <= cmd.func;
			val_q  <= cmd.occupancy[6:0];
		end
		if (load_addr) begin
			acol_q <= acol_d;
			arow_q <= arow_d;
		end
	end

	// global map, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[{arow_q, acol_q}];
	end

	assign busy   = (state_q != lgrm_pkg::T_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_raise_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == lgrm_pkg::ST_RAISED |-> result.stored_value != 7'd0)
		else $error("raised cell with zero value");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == lgrm_pkg::ST_UNKNOWN ||
		result.status == lgrm_pkg::ST_OUTSIDE) |->
		result.target_col == 9'd0 && result.target_row == 9'd0 &&
		result.stored_value == 7'd0)
		else $error("skipped transfer carries nonzero fields");

	a_xform_latency: assert property (@(posedge clk) disable iff (!arst_n)
		xreq.go |-> ##12 xrsp.done)
		else $error("transform did not finish on time");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lgrm_pkg::T_CLEAR |-> !done)
		else $error("result during map clear");

endmodule

>>> hdl/lgrm_xform.sv
// local cell to global cell transform on one shared multiplier under a sequencer
module lgrm_xform (
	input  logic             clk,
	input  logic             arst_n,
	input  lgrm_pkg::cfg_t   cfg,
	input  lgrm_pkg::xf_req_t req,
	output lgrm_pkg::xf_rsp_t rsp
);

	lgrm_pkg::xf_state_t state_q, state_d;

	logic [8:0] col_q, row_q;
	logic signed [10:0] hx, hy;
	logic signed [lgrm_pkg::MUL_A_W-1:0] mul_a;
	logic signed [lgrm_pkg::MUL_B_W-1:0] mul_b;
	logic signed [lgrm_pkg::PROD_W-1:0]  prod_d, prod_q, gacc_q;
	logic signed [31:0] lx_q, ly_q;
	logic signed [lgrm_pkg::ACC_W-1:0] accx_q, accy_q, posex, posey;
	logic [lgrm_pkg::SUM_W-1:0] sum;
	logic [lgrm_pkg::COORD_W-1:0] coord;
	logic coord_in;
	logic [lgrm_pkg::MAP_W-1:0] tcol_q, trow_q;
	logic in_x_q, in_y_q, done_q;

	// half-cell offsets from the local grid centre
	assign hx = $signed({1'b0, col_q, 1'b1}) - $signed({2'b00, cfg.local_cols});
	assign hy = $signed({1'b0, row_q, 1'b1}) - $signed({2'b00, cfg.local_rows});

	assign posex = {{2{cfg.pose_x[31]}}, cfg.pose_x, 15'b0};
	assign posey = {{2{cfg.pose_y[31]}}, cfg.pose_y, 15'b0};

	assign prod_d = mul_a * mul_b;

	// low and high halves of the Q16.16 coordinate times cells per metre
	assign sum   = {{17{gacc_q[lgrm_pkg::PROD_W-1]}}, gacc_q} + {prod_q, 17'b0};
	assign coord = sum[lgrm_pkg::SUM_W-1:32] + lgrm_pkg::COORD_W'(lgrm_pkg::MAP_SIZE / 2);
	assign coord_in = (coord[lgrm_pkg::COORD_W-1:lgrm_pkg::MAP_W] == '0);

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			lgrm_pkg::X_IDLE: begin
				if (req.go) state_d = lgrm_pkg::X_LX;
			end
			lgrm_pkg::X_LX: begin
				mul_a   = {12'b0, cfg.local_resolution};
				mul_b   = {{7{hx[10]}}, hx};
				state_d = lgrm_pkg::X_LY;
			end
			lgrm_pkg::X_LY: begin
				mul_a   = {12'b0, cfg.local_resolution};
				mul_b   = {{7{hy[10]}}, hy};
				state_d = lgrm_pkg::X_WX0;
			end
			lgrm_pkg::X_WX0: begin
				mul_a   = {lx_q[31], lx_q};
				mul_b   = {{2{cfg.cos_yaw[15]}}, cfg.cos_yaw};
				state_d = lgrm_pkg::X_WX1;
			end
			lgrm_pkg::X_WX1: begin
				mul_a   = {ly_q[31], ly_q};
				mul_b   = {{2{cfg.sin_yaw[15]}}, cfg.sin_yaw};
				state_d = lgrm_pkg::X_WY0;
			end
			lgrm_pkg::X_WY0: begin
				mul_a   = {lx_q[31], lx_q};
				mul_b   = {{2{cfg.sin_yaw[15]}}, cfg.sin_yaw};
				state_d = lgrm_pkg::X_WY1;
			end
			lgrm_pkg::X_WY1: begin
				mul_a   = {ly_q[31], ly_q};
				mul_b   = {{2{cfg.cos_yaw[15]}}, cfg.cos_yaw};
				state_d = lgrm_pkg::X_GX0;
			end
			lgrm_pkg::X_GX0: begin
				mul_a   = {6'b0, cfg.global_cells_per_meter};
				mul_b   = {1'b0, accx_q[31:15]};
				state_d = lgrm_pkg::X_GX1;
			end
			lgrm_pkg::X_GX1: begin
				mul_a   = {6'b0, cfg.global_cells_per_meter};
				mul_b   = {accx_q[lgrm_pkg::ACC_W-1], accx_q[lgrm_pkg::ACC_W-1:32]};
				state_d = lgrm_pkg::X_GY0;
			end
			lgrm_pkg::X_GY0: begin
				mul_a   = {6'b0, cfg.global_cells_per_meter};
				mul_b   = {1'b0, accy_q[31:15]};
				state_d = lgrm_pkg::X_GY1;
			end
			lgrm_pkg::X_GY1: begin
				mul_a   = {6'b0, cfg.global_cells_per_meter};
				mul_b   = {accy_q[lgrm_pkg::ACC_W-1], accy_q[lgrm_pkg::ACC_W-1:32]};
				state_d = lgrm_pkg::X_DONE;
			end
			lgrm_pkg::X_DONE: begin
				state_d = lgrm_pkg::X_IDLE;
			end
			default: state_d = lgrm_pkg::X_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgrm_pkg::X_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == lgrm_pkg::X_DONE);
		end
	end

	// product of the previous step is consumed while the next one is formed
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (state_q)
			lgrm_pkg::X_IDLE: begin
				if (req.go) begin
					col_q <= req.col;
					row_q <= req.row;
				end
			end
			lgrm_pkg::X_LY:  lx_q   <= prod_q[31:0];
			lgrm_pkg::X_WX0: ly_q   <= prod_q[31:0];
			lgrm_pkg::X_WX1: accx_q <= posex + prod_q[lgrm_pkg::ACC_W-1:0];
			lgrm_pkg::X_WY0: accx_q <= accx_q - prod_q[lgrm_pkg::ACC_W-1:0];
			lgrm_pkg::X_WY1: accy_q <= posey + prod_q[lgrm_pkg::ACC_W-1:0];
			lgrm_pkg::X_GX0: accy_q <= accy_q + prod_q[lgrm_pkg::ACC_W-1:0];
			lgrm_pkg::X_GX1: gacc_q <= prod_q;
			lgrm_pkg::X_GY0: begin
				tcol_q <= coord[lgrm_pkg::MAP_W-1:0];
				in_x_q <= coord_in;
			end
			lgrm_pkg::X_GY1: gacc_q <= prod_q;
			lgrm_pkg::X_DONE: begin
				trow_q <= coord[lgrm_pkg::MAP_W-1:0];
				in_y_q <= coord_in;
			end
			default: ;
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.on_map = in_x_q & in_y_q;
	assign rsp.col    = tcol_q;
	assign rsp.row    = trow_q;

endmodule
